// ===== src/bsd_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream decoder.
// No dependencies; imported by every module of the block.
package bsd_pkg;

  // Depth of the group queue between the front and the back.
  localparam int GrpDepth = 4;
  localparam int PtrW     = $clog2(GrpDepth);

  // Character classes.
  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindTerm = 2'd1;
  localparam logic [1:0] KindSkip = 2'd2;

  // Special alphabet values.
  localparam logic [5:0] Val62 = 6'd62;
  localparam logic [5:0] Val63 = 6'd63;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] val;
  } code_t;

  // One group of results caused by one input item (1 to 3 results).
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] n;    // number of results in the group
    logic       has;  // 0: single end marker without a byte
    logic       eom;  // last result of the group ends the message
  } grp_t;

  // Map one character to a sextet, a terminator or a skip.
  function automatic code_t map_char(input logic [7:0] ch, input logic url);
    code_t c;
    c.kind = KindSkip;
    c.val  = '0;
    if (ch[7]) begin
      c.kind = KindSkip;
    end else if (ch == 8'h00 || ch == 8'h3D) begin
      c.kind = KindTerm;
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      c.kind = KindData;
      c.val  = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      c.kind = KindData;
      c.val  = 6'(ch - 8'h47);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      c.kind = KindData;
      c.val  = 6'(ch + 8'h04);
    end else if (url && ch == 8'h2D) begin
      c.kind = KindData;
      c.val  = Val62;
    end else if (url && ch == 8'h5F) begin
      c.kind = KindData;
      c.val  = Val63;
    end else if (!url && ch == 8'h2B) begin
      c.kind = KindData;
      c.val  = Val62;
    end else if (!url && ch == 8'h2F) begin
      c.kind = KindData;
      c.val  = Val63;
    end
    return c;
  endfunction

endpackage

// ===== src/bsd_front.sv =====
// Front of the decoder: accepts characters, classifies them and gathers sextets.
// Emits one result group per item that causes results. Uses bsd_pkg.
module bsd_front import bsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       url_i,
  input  logic       acc_i,
  input  logic [7:0] in_char_i,
  input  logic       last_char_i,
  output logic       grp_push_o,
  output grp_t       grp_o
);

  logic [5:0] s0_q, s1_q, s2_q;
  logic [1:0] cnt_q, cnt_d, cnt_new;
  logic       skip_q, skip_d;
  code_t      code;
  logic       is_data, is_term, blk, store, fin;
  logic [5:0] e0, e1, e2;

  // Classify the character
  always_comb begin
    code    = map_char(in_char_i, url_i);
    is_data = !skip_q && code.kind == KindData;
    is_term = !skip_q && code.kind == KindTerm;
    blk     = is_data && cnt_q == 2'd3;
    store   = is_data && cnt_q != 2'd3;
    fin     = !skip_q && (is_term || (last_char_i && !blk));
    cnt_new = blk ? 2'd0 : (store ? cnt_q + 2'd1 : cnt_q);
    e0      = (store && cnt_q == 2'd0) ? code.val : s0_q;
    e1      = (store && cnt_q == 2'd1) ? code.val : s1_q;
    e2      = (store && cnt_q == 2'd2) ? code.val : s2_q;
  end

  // Build the result group
  always_comb begin
    grp_o.b0  = {e0, e1[5:4]};
    grp_o.b1  = {e1[3:0], e2[5:2]};
    grp_o.b2  = {e2[1:0], code.val};
    grp_o.n   = 2'd1;
    grp_o.has = 1'b1;
    grp_o.eom = 1'b1;
    if (blk) begin
      grp_o.n   = 2'd3;
      grp_o.eom = last_char_i;
    end else if (cnt_new == 2'd3) begin
      grp_o.n = 2'd2;
    end else if (cnt_new != 2'd2) begin
      grp_o.has = 1'b0;
      grp_o.b0  = '0;
    end
    grp_push_o = acc_i && (blk || fin);
  end

  // Next state
  always_comb begin
    cnt_d  = cnt_q;
    skip_d = skip_q;
    if (acc_i) begin
      if (skip_q) begin
        if (last_char_i) begin
          skip_d = 1'b0;
        end
      end else begin
        cnt_d  = fin ? 2'd0 : cnt_new;
        skip_d = is_term && !last_char_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      skip_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      skip_q <= skip_d;
    end
  end

  // Sextet buffer, no reset
  always_ff @(posedge clk_i) begin
    if (acc_i && store) begin
      s0_q <= e0;
      s1_q <= e1;
      s2_q <= e2;
    end
  end

endmodule

// ===== src/bsd_fifo.sv =====
// Short queue of result groups between the front and the back.
// Uses grp_t and GrpDepth from bsd_pkg.
module bsd_fifo import bsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output grp_t data_o
);

  grp_t          mem_q [GrpDepth];
  logic [PtrW:0] wr_q, rd_q;

  assign empty_o = wr_q == rd_q;
  assign full_o  = (wr_q[PtrW] != rd_q[PtrW]) && (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]);
  assign data_o  = mem_q[rd_q[PtrW-1:0]];

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= wr_q + (PtrW+1)'(1);
      end
      if (pop_i && !empty_o) begin
        rd_q <= rd_q + (PtrW+1)'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q[PtrW-1:0]] <= data_i;
    end
  end

endmodule

// ===== src/bsd_back.sv =====
// Back of the decoder: splits result groups into single results and holds
// the output register. Uses grp_t from bsd_pkg.
module bsd_back import bsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       grp_empty_i,
  input  grp_t       grp_i,
  output logic       grp_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       end_of_message_o
);

  logic [1:0] idx_q, idx_d;
  logic       ov_q;
  logic       load, last_in_grp;
  logic [7:0] sel_byte;

  // Pick the current byte of the head group
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = grp_i.b0;
      2'd1:    sel_byte = grp_i.b1;
      default: sel_byte = grp_i.b2;
    endcase
    last_in_grp = idx_q == grp_i.n - 2'd1;
    load        = !grp_empty_i && (!ov_q || pop_i);
    grp_pop_o   = load && last_in_grp;
    idx_d       = idx_q;
    if (load) begin
      idx_d = last_in_grp ? 2'd0 : idx_q + 2'd1;
    end
  end

  assign empty_o = !ov_q;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o       <= sel_byte;
      has_byte_o       <= grp_i.has;
      end_of_message_o <= grp_i.eom && last_in_grp;
    end
  end

endmodule

// ===== src/base64_stream_decoder_core.sv =====
// Top level of the base64 stream decoder.
// Instantiates bsd_front, bsd_fifo and bsd_back; uses bsd_pkg.

// Takes one encoded character per cycle while full is low and returns decoded
// bytes one per cycle through a result queue interface. Four alphabet characters
// give three bytes; NUL or '=' ends a message and flushes the pending bytes, and
// the last result of every message has end_of_message set (an end marker with
// has_byte low when no byte is left). A character is classified and its group
// of up to three results is built in the cycle it is accepted; the group is then
// queued and registered at the output. Input rate is one item per cycle; output
// rate is one result per cycle while pop is high, set by the single back-end
// output register, and a four-entry group queue absorbs bursts. url_alphabet
// selects '-' '_' instead of '+' '/'; write it only while the block is idle.
module base64_stream_decoder_core import bsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       url_alphabet_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       last_char_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       end_of_message_o
);

  logic url_q;
  logic acc, grp_push, grp_pop, grp_empty;
  grp_t grp_in, grp_head;

  assign cfg_ready_o = 1'b1;
  assign acc         = push && !full;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      url_q <= url_alphabet_i;
    end
  end

  bsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .url_i       (url_q),
    .acc_i       (acc),
    .in_char_i   (in_char_i),
    .last_char_i (last_char_i),
    .grp_push_o  (grp_push),
    .grp_o       (grp_in)
  );

  bsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .full_o  (full),
    .pop_i   (grp_pop),
    .empty_o (grp_empty),
    .data_o  (grp_head)
  );

  bsd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .grp_empty_i      (grp_empty),
    .grp_i            (grp_head),
    .grp_pop_o        (grp_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .out_byte_o       (out_byte_o),
    .has_byte_o       (has_byte_o),
    .end_of_message_o (end_of_message_o)
  );

  // A group is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) grp_push |-> !full)
    else $error("group pushed into full queue");

  // An end marker without a byte always closes the message and carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_byte_o) |-> (end_of_message_o && out_byte_o == 8'h00))
    else $error("malformed end marker");

  // The back only takes a group off a queue that holds one
  assert property (@(posedge clk_i) disable iff (!rst_ni) grp_pop |-> !grp_empty)
    else $error("group popped from empty queue");

endmodule

// ===== tb/base64_stream_decoder_core_tb.sv =====
// Self-checking testbench for base64_stream_decoder_core: directed corner cases,
// then random well-formed, truncated and noisy messages under both alphabets.
// Depends on bsd_pkg (character class codes) and the decoder RTL.
module base64_stream_decoder_core_tb import bsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChPad = 8'h3D;  // '='

  // Receiver stall modes
  localparam int PopAlways = 0;
  localparam int PopCoin   = 1;
  localparam int PopMask   = 2;
  localparam int PopSparse = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eom;
  } dec_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_url = 1'b0;
  logic       item_push = 1'b0;
  logic       full;
  logic [7:0] char_in = 8'h00;
  logic       last_in = 1'b0;
  logic       empty;
  logic       result_pop = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_msg;

  base64_stream_decoder_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .url_alphabet_i   (cfg_url),
    .push             (item_push),
    .full             (full),
    .in_char_i        (char_in),
    .last_char_i      (last_in),
    .empty            (empty),
    .pop              (result_pop),
    .out_byte_o       (out_byte),
    .has_byte_o       (has_byte),
    .end_of_message_o (end_of_msg)
  );

  // Characters waiting to be sent and decoded bytes waiting to come out
  char_item_t  chars_pending[$];
  dec_result_t bytes_expected[$];

  // Shadow decoder state
  logic        alphabet_sel = 1'b0;
  logic [5:0]  sext_buf [3];
  logic [1:0]  sext_cnt = 2'd0;
  logic        skip_rest = 1'b0;
  dec_result_t step_res [3];
  int          step_n;

  int  n_errors = 0;
  int  n_chars = 0;
  int  n_results = 0;
  int  n_markers = 0;
  int  n_msgs = 0;
  logic item_took = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sort one character into data / terminator / dropped
  function automatic void classify(input logic [7:0] ch, input logic url,
                                   output logic [1:0] kind, output logic [5:0] val);
    kind = KindSkip;
    val  = 6'd0;
    if (ch[7]) begin
      kind = KindSkip;
    end else if (ch == ChNul || ch == ChPad) begin
      kind = KindTerm;
    end else if (ch >= "A" && ch <= "Z") begin
      kind = KindData;
      val  = 6'(ch - 8'h41);
    end else if (ch >= "a" && ch <= "z") begin
      kind = KindData;
      val  = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= "0" && ch <= "9") begin
      kind = KindData;
      val  = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == (url ? 8'h2D : 8'h2B)) begin
      kind = KindData;
      val  = 6'd62;
    end else if (ch == (url ? 8'h5F : 8'h2F)) begin
      kind = KindData;
      val  = 6'd63;
    end
  endfunction

  function automatic void stage_byte(input logic [7:0] b, input logic eom);
    step_res[step_n] = '{data: b, has: 1'b1, eom: eom};
    step_n++;
  endfunction

  // Flush what is pending and mark the end of the message
  function automatic void close_message();
    if (sext_cnt == 2'd3) begin
      stage_byte({sext_buf[0], sext_buf[1][5:4]}, 1'b0);
      stage_byte({sext_buf[1][3:0], sext_buf[2][5:2]}, 1'b1);
    end else if (sext_cnt == 2'd2) begin
      stage_byte({sext_buf[0], sext_buf[1][5:4]}, 1'b1);
    end else if (step_n > 0) begin
      step_res[step_n - 1].eom = 1'b1;
    end else begin
      step_res[0] = '{data: 8'h00, has: 1'b0, eom: 1'b1};
      step_n = 1;
    end
    sext_cnt = 2'd0;
  endfunction

  // Work out the results one accepted character causes
  function automatic void decode_char(input logic [7:0] ch, input logic last);
    logic [1:0] kind;
    logic [5:0] val;
    step_n = 0;
    if (skip_rest) begin
      if (last) skip_rest = 1'b0;
    end else begin
      classify(ch, alphabet_sel, kind, val);
      if (kind == KindTerm) begin
        if (!last) skip_rest = 1'b1;
        close_message();
      end else begin
        if (kind == KindData) begin
          if (sext_cnt < 2'd3) begin
            sext_buf[sext_cnt] = val;
            sext_cnt++;
          end else begin
            stage_byte({sext_buf[0], sext_buf[1][5:4]}, 1'b0);
            stage_byte({sext_buf[1][3:0], sext_buf[2][5:2]}, 1'b0);
            stage_byte({sext_buf[2][1:0], val}, 1'b0);
            sext_cnt = 2'd0;
          end
        end
        if (last) close_message();
      end
    end
    for (int i = 0; i < step_n; i++) bytes_expected.push_back(step_res[i]);
  endfunction

  // Encoder side for building stimulus
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return alphabet_sel ? 8'h2D : 8'h2B;
    return alphabet_sel ? 8'h5F : 8'h2F;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0: return {1'b1, 7'($urandom)};
      // the other alphabet's specials
      1: return alphabet_sel ? ($urandom_range(0, 1) ? 8'h2B : 8'h2F)
                             : ($urandom_range(0, 1) ? 8'h2D : 8'h5F);
      2: return $urandom_range(0, 1) ? 8'h7F : 8'h20;
      default: return $urandom_range(0, 1) ? 8'h0A : 8'h2E;
    endcase
  endfunction

  task automatic add_item(input logic [7:0] ch, input logic last);
    chars_pending.push_back('{ch: ch, last: last});
  endtask

  task automatic add_string(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) add_item(s[i], last && (i == s.len() - 1));
  endtask

  // Encoded random payload, optional padding/terminator, sprinkled noise
  task automatic add_wellformed();
    logic [7:0]  payload[$];
    logic [7:0]  txt[$];
    logic [23:0] w;
    int nb, rem;
    nb = $urandom_range(0, 7);
    for (int i = 0; i < nb; i++) payload.push_back(8'($urandom));
    for (int i = 0; i < nb; i += 3) begin
      rem = nb - i;
      w = {payload[i], (rem > 1) ? payload[i + 1] : 8'h00,
           (rem > 2) ? payload[i + 2] : 8'h00};
      txt.push_back(sextet_char(w[23:18]));
      txt.push_back(sextet_char(w[17:12]));
      if (rem > 1) txt.push_back(sextet_char(w[11:6]));
      if (rem > 2) begin
        txt.push_back(sextet_char(w[5:0]));
      end else if ($urandom_range(0, 1)) begin
        txt.push_back(ChPad);
        if (rem == 1) txt.push_back(ChPad);
      end
    end
    if (txt.size() == 0 || $urandom_range(0, 3) == 0)
      txt.push_back($urandom_range(0, 1) ? ChPad : ChNul);
    for (int i = 0; i < txt.size(); i++) begin
      if ($urandom_range(0, 7) == 0) add_item(noise_char(), 1'b0);
      add_item(txt[i], i == txt.size() - 1);
    end
  endtask

  // Terminator in the middle, then junk up to the flagged last character
  task automatic add_early_end();
    int nv, nj;
    nv = $urandom_range(0, 6);
    nj = $urandom_range(0, 4);
    for (int i = 0; i < nv; i++) add_item(sextet_char(6'($urandom)), 1'b0);
    add_item($urandom_range(0, 1) ? ChPad : ChNul, 1'b0);
    for (int i = 0; i < nj; i++) add_item(8'($urandom), 1'b0);
    add_item(8'($urandom), 1'b1);
  endtask

  task automatic add_raw_bytes();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) add_item(8'($urandom), i == n - 1);
  endtask

  task automatic load_random(input int count);
    int start;
    int pick;
    start = chars_pending.size();
    while (chars_pending.size() - start < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) add_wellformed();
      else if (pick < 8) add_early_end();
      else add_raw_bytes();
    end
  endtask

  task automatic load_directed();
    add_string("TWFu", 1'b1);      // group of four completed by the last char
    add_string("TWE=", 1'b1);      // three pending at end: two bytes
    add_string("TQ==", 1'b1);      // two pending, pad before last: skip to last
    add_string("T", 1'b0);         // one pending then NUL: sextet discarded
    add_item(ChNul, 1'b1);
    add_item(8'hFF, 1'b1);         // high-bit last char, nothing pending: marker
    add_string("+/-_z0", 1'b1);    // standard specials; url specials dropped
    add_item(8'h7F, 1'b0);         // outside alphabet
    add_item(8'h80, 1'b0);         // lowest high-bit char
    add_string("a", 1'b1);
  endtask

  // Sender stays off until every result is out and the pipe has drained
  task automatic wait_idle();
    while (chars_pending.size() != 0 || item_push || bytes_expected.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_alphabet(input logic url);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_url   <= url;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    alphabet_sel = url;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Character driver: bursts with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      item_push <= 1'b0;
    end else if (item_push && !item_took) begin
      // hold the offered item until taken
    end else if (gap_left > 0) begin
      item_push <= 1'b0;
      gap_left = gap_left - 1;
    end else if (chars_pending.size() != 0) begin
      item_push <= 1'b1;
      char_in   <= chars_pending[0].ch;
      last_in   <= chars_pending[0].last;
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      item_push <= 1'b0;
    end
  end

  // Result receiver: stall mode is picked anew at random intervals
  int         pop_mode = PopAlways;
  int         pop_left = 0;
  logic [7:0] pop_mask = 8'hFF;
  always @(negedge clk_i) begin
    if (pop_left == 0) begin
      pop_mode = $urandom_range(PopAlways, PopSparse);
      pop_mask = 8'($urandom) | 8'h01;
      pop_left = $urandom_range(20, 80);
    end
    pop_left = pop_left - 1;
    case (pop_mode)
      PopAlways: result_pop <= 1'b1;
      PopCoin:   result_pop <= 1'($urandom_range(0, 1));
      PopMask: begin
        result_pop <= pop_mask[0];
        pop_mask = {pop_mask[0], pop_mask[7:1]};
      end
      default:   result_pop <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Accept characters into the predictor and check results
  dec_result_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      item_took = item_push && !full;
      if (item_took) begin
        void'(chars_pending.pop_front());
        decode_char(char_in, last_in);
        n_chars++;
      end
      if (result_pop && !empty) begin
        n_results++;
        if (!has_byte) n_markers++;
        if (end_of_msg) n_msgs++;
        if (bytes_expected.size() == 0) begin
          $display("%0t: unexpected result byte=%02h has=%0b eom=%0b",
                   $realtime, out_byte, has_byte, end_of_msg);
          n_errors++;
        end else begin
          want = bytes_expected.pop_front();
          if (out_byte !== want.data || has_byte !== want.has
              || end_of_msg !== want.eom) begin
            $display("%0t: mismatch expected byte=%02h has=%0b eom=%0b",
                     $realtime, want.data, want.has, want.eom);
            $display("%0t:          actual   byte=%02h has=%0b eom=%0b",
                     $realtime, out_byte, has_byte, end_of_msg);
            n_errors++;
          end
        end
      end
    end
  end

  // Phases: directed in the standard alphabet, then random under both
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    write_alphabet(1'b0);
    load_directed();
    wait_idle();
    write_alphabet(1'b1);
    load_random(45);
    wait_idle();
    write_alphabet(1'b0);
    load_random(45);
    wait_idle();
    write_alphabet(1'b1);
    load_random(40);
    wait_idle();
    if (bytes_expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, bytes_expected.size());
      n_errors++;
    end
    $display("Decoded %0d characters into %0d results (%0d end markers, %0d messages)",
             n_chars, n_results, n_markers, n_msgs);
    $display("Both alphabets exercised with padded, truncated and noisy messages");
    if (n_errors == 0) begin
      $display("PASS base64_stream_decoder_core");
    end else begin
      $display("FAIL base64_stream_decoder_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("FAIL base64_stream_decoder_core");
    $finish;
  end

endmodule
